// ===== rtl/msfe_pkg.sv =====
// Shared types, constants and a helper function for the motor sensing front end.
`default_nettype none

package msfe_pkg;

  localparam int ELEC_PER_MECH   = 7;
  localparam int MAX_ENC_FAILS   = 3;
  localparam int CURRENT_SHIFT   = 2;
  localparam int SPEED_SHIFT     = 3;
  localparam bit INVERT_POLARITY = 1'b0;
  localparam int LEAD_CLAMP      = 2730;

  localparam int ANGLE_W = 15;
  localparam int SAMPLE_W = 12;
  localparam int GAIN_W = 16;
  localparam int CUR_W = 24;
  localparam int LIMIT_W = 23;
  localparam int CFG_W = 23;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    FAULT_NONE        = 2'd0,
    FAULT_OVERCURRENT = 2'd1,
    FAULT_ENCODER     = 2'd2
  } fault_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_OFFSET_A = 3'd0,
    REG_ZERO_OFFSET_B = 3'd1,
    REG_ZERO_OFFSET_C = 3'd2,
    REG_GAIN_A        = 3'd3,
    REG_GAIN_BC       = 3'd4,
    REG_OC_LIMIT      = 3'd5,
    REG_ANGLE_OFFSET  = 3'd6,
    REG_LEAD_MIN      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                encoder_ok;
    logic [ANGLE_W-1:0]  mech_angle;
    logic                adc_ready;
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic                arm;
  } msfe_in_t;

  typedef struct packed {
    logic [1:0]              fault_code;
    logic                    drive_on;
    logic                    neutral_pwm;
    logic [ANGLE_W-1:0]      elec_angle_out;
    logic signed [CUR_W-1:0] current_a;
    logic signed [CUR_W-1:0] current_b;
    logic signed [CUR_W-1:0] current_c;
    logic signed [CUR_W-1:0] speed_out;
  } msfe_out_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] zero_offset_a;
    logic [SAMPLE_W-1:0] zero_offset_b;
    logic [SAMPLE_W-1:0] zero_offset_c;
    logic [GAIN_W-1:0]   gain_a;
    logic [GAIN_W-1:0]   gain_bc;
    logic [LIMIT_W-1:0]  overcurrent_limit;
    logic [ANGLE_W-1:0]  angle_offset;
    logic [LIMIT_W-1:0]  lead_min_speed;
  } msfe_cfg_t;

  // One classified tick on its way from the front to the back.
  typedef struct packed {
    logic                    arm;
    logic                    enc_fault;
    logic [ANGLE_W-1:0]      angle;
    logic signed [CUR_W-1:0] raw_a;
    logic signed [CUR_W-1:0] raw_b;
    logic signed [CUR_W-1:0] raw_c;
  } msfe_cmd_t;

  function automatic logic signed [CUR_W-1:0] sat24(input logic signed [26:0] v);
    logic signed [26:0] hi;
    logic signed [26:0] lo;
    hi = 27'sd8388607;
    lo = -27'sd8388608;
    if (v > hi) return 24'sh7FFFFF;
    else if (v < lo) return 24'sh800000;
    else return v[CUR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/msfe_front.sv =====
// Front part: encoder failure counting, sample hold, angle and raw current scaling.
`default_nettype none

module msfe_front import msfe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire msfe_in_t  in_data,
  input  wire msfe_cfg_t cfg,
  output logic           cmd_valid,
  input  wire logic      cmd_ready,
  output msfe_cmd_t      cmd
);

  logic [7:0]          fail_run_r, fail_run_nxt;
  logic [SAMPLE_W-1:0] held_a_r, held_b_r, held_c_r;
  logic [SAMPLE_W-1:0] samp_a, samp_b, samp_c;
  logic                accept;
  logic                enc_fault;
  logic [21:0]         mech_scaled;

  function automatic logic signed [CUR_W-1:0] raw_current(
    input logic [SAMPLE_W-1:0] s,
    input logic [SAMPLE_W-1:0] z,
    input logic [GAIN_W-1:0]   g
  );
    logic signed [12:0] d;
    logic signed [29:0] p;
    logic signed [26:0] v;
    d = $signed({1'b0, s}) - $signed({1'b0, z});
    p = d * $signed({1'b0, g});
    v = 27'(p >>> 4);
    if (INVERT_POLARITY) v = -v;
    return sat24(v);
  endfunction

  assign accept    = in_valid && cmd_ready;
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;

  always_comb begin
    fail_run_nxt = fail_run_r;
    if (!in_data.encoder_ok) begin
      if (fail_run_r != 8'hFF) fail_run_nxt = fail_run_r + 8'd1;
    end else begin
      fail_run_nxt = '0;
    end
  end

  assign enc_fault = !in_data.encoder_ok && (fail_run_nxt >= 8'(MAX_ENC_FAILS));

  assign samp_a = in_data.adc_ready ? in_data.sample_a : held_a_r;
  assign samp_b = in_data.adc_ready ? in_data.sample_b : held_b_r;
  assign samp_c = in_data.adc_ready ? in_data.sample_c : held_c_r;

  assign mech_scaled = 22'(in_data.mech_angle) * 22'(ELEC_PER_MECH);

  always_comb begin
    cmd.arm       = in_data.arm;
    cmd.enc_fault = enc_fault;
    cmd.angle     = mech_scaled[ANGLE_W-1:0] - cfg.angle_offset;
    cmd.raw_a     = raw_current(samp_a, cfg.zero_offset_a, cfg.gain_a);
    cmd.raw_b     = raw_current(samp_b, cfg.zero_offset_b, cfg.gain_bc);
    cmd.raw_c     = raw_current(samp_c, cfg.zero_offset_c, cfg.gain_bc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_run_r <= '0;
      held_a_r   <= '0;
      held_b_r   <= '0;
      held_c_r   <= '0;
    end else if (accept) begin
      fail_run_r <= fail_run_nxt;
      // samples are not taken on a tick lost to an encoder fault
      if (!enc_fault && in_data.adc_ready) begin
        held_a_r <= in_data.sample_a;
        held_b_r <= in_data.sample_b;
        held_c_r <= in_data.sample_c;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/msfe_queue.sv =====
// Two-entry queue of classified words between front and back.
`default_nettype none

module msfe_queue import msfe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire msfe_cmd_t push_data,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output msfe_cmd_t      pop_data
);

  msfe_cmd_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/msfe_back.sv =====
// Back part: speed and current filters, drive enable and faults, angle lead, result register.
`default_nettype none

module msfe_back import msfe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cmd_valid,
  output logic           cmd_ready,
  input  wire msfe_cmd_t cmd,
  input  wire msfe_cfg_t cfg,
  output logic           out_valid,
  input  wire logic      out_ready,
  output msfe_out_t      out_data
);

  localparam logic signed [15:0] LEAD_HI = 16'(LEAD_CLAMP);
  localparam logic signed [15:0] LEAD_LO = -16'(LEAD_CLAMP);

  logic [ANGLE_W-1:0]      prev_angle_r;
  logic signed [CUR_W-1:0] speed_r, speed_nxt;
  logic                    seen_r;
  logic signed [CUR_W-1:0] filt_a_r, filt_b_r, filt_c_r;
  logic signed [CUR_W-1:0] filt_a_nxt, filt_b_nxt, filt_c_nxt;
  logic                    enabled_r, enabled_nxt;
  fault_t                  fault_r, fault_nxt;
  logic                    out_valid_r;
  msfe_out_t               out_data_r, out_data_nxt;

  logic                    take;
  logic                    en0;
  fault_t                  f0;
  logic [ANGLE_W-1:0]      d;
  logic signed [24:0]      sdiff, sshift;
  logic signed [26:0]      ssum;
  logic                    overcurrent;
  logic                    lead_due;
  logic signed [24:0]      biased;
  logic signed [15:0]      quot;
  logic signed [12:0]      lead;
  logic [ANGLE_W-1:0]      lead_angle;

  function automatic logic signed [CUR_W-1:0] filt_step(
    input logic signed [CUR_W-1:0] filt,
    input logic signed [CUR_W-1:0] raw
  );
    logic signed [24:0] diff;
    logic signed [24:0] sh;
    logic signed [26:0] sum;
    diff = {raw[CUR_W-1], raw} - {filt[CUR_W-1], filt};
    sh   = diff >>> CURRENT_SHIFT;
    sum  = {{3{filt[CUR_W-1]}}, filt} + {{2{sh[24]}}, sh};
    return sat24(sum);
  endfunction

  function automatic logic [CUR_W-1:0] abs24(input logic signed [CUR_W-1:0] v);
    return v[CUR_W-1] ? (~v + 24'd1) : v;
  endfunction

  assign cmd_ready = !out_valid_r || out_ready;
  assign take      = cmd_valid && cmd_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign en0 = cmd.arm ? 1'b1 : enabled_r;
  assign f0  = cmd.arm ? FAULT_NONE : fault_r;

  // speed: wrapped 15-bit delta, scaled by 256, first-order filter
  always_comb begin
    d      = cmd.angle - prev_angle_r;
    sdiff  = {{2{d[ANGLE_W-1]}}, d, 8'd0} - {speed_r[CUR_W-1], speed_r};
    sshift = sdiff >>> SPEED_SHIFT;
    ssum   = {{3{speed_r[CUR_W-1]}}, speed_r} + {{2{sshift[24]}}, sshift};
    speed_nxt = seen_r ? sat24(ssum) : '0;
  end

  assign filt_a_nxt = filt_step(filt_a_r, cmd.raw_a);
  assign filt_b_nxt = filt_step(filt_b_r, cmd.raw_b);
  assign filt_c_nxt = filt_step(filt_c_r, cmd.raw_c);

  assign overcurrent = (abs24(filt_a_nxt) > {1'b0, cfg.overcurrent_limit})
                    || (abs24(filt_b_nxt) > {1'b0, cfg.overcurrent_limit})
                    || (abs24(filt_c_nxt) > {1'b0, cfg.overcurrent_limit});

  // lead = speed / 256 rounded toward zero, clamped
  always_comb begin
    lead_due = abs24(speed_nxt) >= {1'b0, cfg.lead_min_speed};
    biased   = {speed_nxt[CUR_W-1], speed_nxt}
             + (speed_nxt[CUR_W-1] ? 25'sd255 : 25'sd0);
    quot     = 16'(biased >>> 8);
    if (quot > LEAD_HI) lead = LEAD_HI[12:0];
    else if (quot < LEAD_LO) lead = LEAD_LO[12:0];
    else lead = quot[12:0];
    lead_angle = cmd.angle + {{2{lead[12]}}, lead};
  end

  always_comb begin
    enabled_nxt = en0;
    fault_nxt   = f0;
    out_data_nxt.current_a = filt_a_nxt;
    out_data_nxt.current_b = filt_b_nxt;
    out_data_nxt.current_c = filt_c_nxt;
    out_data_nxt.speed_out = speed_nxt;
    out_data_nxt.elec_angle_out = cmd.angle;
    out_data_nxt.neutral_pwm = 1'b1;
    if (cmd.enc_fault) begin
      enabled_nxt = 1'b0;
      fault_nxt   = FAULT_ENCODER;
      out_data_nxt.current_a = filt_a_r;
      out_data_nxt.current_b = filt_b_r;
      out_data_nxt.current_c = filt_c_r;
      out_data_nxt.speed_out = speed_r;
      out_data_nxt.elec_angle_out = prev_angle_r;
    end else if (!en0) begin
      enabled_nxt = 1'b0;
    end else if (overcurrent) begin
      enabled_nxt = 1'b0;
      fault_nxt   = FAULT_OVERCURRENT;
    end else begin
      out_data_nxt.neutral_pwm = 1'b0;
      if (lead_due) out_data_nxt.elec_angle_out = lead_angle;
    end
    out_data_nxt.fault_code = fault_nxt;
    out_data_nxt.drive_on   = enabled_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_angle_r <= '0;
      speed_r      <= '0;
      seen_r       <= 1'b0;
      filt_a_r     <= '0;
      filt_b_r     <= '0;
      filt_c_r     <= '0;
      enabled_r    <= 1'b0;
      fault_r      <= FAULT_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        enabled_r <= enabled_nxt;
        fault_r   <= fault_nxt;
        if (!cmd.enc_fault) begin
          prev_angle_r <= cmd.angle;
          speed_r      <= speed_nxt;
          seen_r       <= 1'b1;
          filt_a_r     <= filt_a_nxt;
          filt_b_r     <= filt_b_nxt;
          filt_c_r     <= filt_c_nxt;
        end
      end
      if (take) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/motor_sense_front_end.sv =====
// Top level of the motor sensing front end: configuration registers and the front/queue/back chain.
//
// One input word per PWM tick on in_valid/in_ready: encoder angle and status, three raw
// phase ADC samples, adc_ready and arm. One result word per input on out_valid/out_ready:
// fault code, drive enable, neutral PWM flag, electrical angle (with speed lead when
// enabled), three filtered phase currents and the filtered speed.
// An accepted word passes through a queue entry and then the output register to out_valid.
// Throughput: one word per cycle while out_ready stays high; the speed and current filter
// updates and the fault logic in the back stage are combinational ahead of the output register.
// The front classifies each word (encoder failure run, sample hold, angle, scaled raw
// current) and pushes it into a two-entry queue; the back applies the filters and the
// enable/fault logic and holds the result in an output register.
// When the receiver stalls, the output register holds and the queue keeps taking words
// until it is full, then in_ready drops.
// Reset (rst_n low, synchronous) clears all filter and fault state, drops the drive and
// returns the configuration registers to their defaults. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect at once and are meant for when the block is idle.
`default_nettype none

module motor_sense_front_end import msfe_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire msfe_in_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output msfe_out_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  msfe_cfg_t cfg_r;
  msfe_cmd_t front_cmd, back_cmd;
  logic      front_valid, front_ready;
  logic      back_valid, back_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_offset_a     <= 12'd2048;
      cfg_r.zero_offset_b     <= 12'd2048;
      cfg_r.zero_offset_c     <= 12'd2048;
      cfg_r.gain_a            <= '0;
      cfg_r.gain_bc           <= '0;
      cfg_r.overcurrent_limit <= '1;
      cfg_r.angle_offset      <= '0;
      cfg_r.lead_min_speed    <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ZERO_OFFSET_A: cfg_r.zero_offset_a     <= cfg_data[SAMPLE_W-1:0];
        REG_ZERO_OFFSET_B: cfg_r.zero_offset_b     <= cfg_data[SAMPLE_W-1:0];
        REG_ZERO_OFFSET_C: cfg_r.zero_offset_c     <= cfg_data[SAMPLE_W-1:0];
        REG_GAIN_A:        cfg_r.gain_a            <= cfg_data[GAIN_W-1:0];
        REG_GAIN_BC:       cfg_r.gain_bc           <= cfg_data[GAIN_W-1:0];
        REG_OC_LIMIT:      cfg_r.overcurrent_limit <= cfg_data[LIMIT_W-1:0];
        REG_ANGLE_OFFSET:  cfg_r.angle_offset      <= cfg_data[ANGLE_W-1:0];
        REG_LEAD_MIN:      cfg_r.lead_min_speed    <= cfg_data[LIMIT_W-1:0];
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  msfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  msfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd)
  );

  msfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/msfe_checker.sv =====
// Port-level checks for the motor sensing front end, bound to the top level.
`default_nettype none

module msfe_checker import msfe_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire msfe_out_t out_data
);

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the PWM is driven exactly when the drive is on
  a_neutral_vs_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.drive_on != out_data.neutral_pwm))
    else $error("neutral_pwm does not match drive_on");

  // a reported fault always leaves the drive off
  a_fault_drive_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.fault_code != FAULT_NONE) |-> !out_data.drive_on)
    else $error("drive on with a fault reported");

endmodule

bind motor_sense_front_end msfe_checker u_msfe_checker (.*);

`default_nettype wire

// ===== dv/tb_motor_sense_front_end.sv =====
// Self-checking testbench for motor_sense_front_end: directed, fault and random tick streams.
`default_nettype none

module tb_motor_sense_front_end;
  timeunit 1ns;
  timeprecision 1ps;

  import msfe_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  msfe_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  msfe_out_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  motor_sense_front_end uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the block's registers and filter state
  msfe_cfg_t   regs;
  logic [7:0]  enc_miss_run;
  logic [14:0] last_angle;
  longint      speed_est;
  bit          speed_primed;
  logic [11:0] latched_adc[3];
  longint      phase_filt[3];
  bit          drive_en;
  fault_t      fault_state;

  msfe_out_t due_results[$];
  int        mismatches = 0;
  int        words_seen = 0;
  bit        idling_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint clip24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint scaled_current(input logic [11:0] s, input logic [11:0] z,
                                            input logic [15:0] g);
    longint v;
    v = (longint'(s) - longint'(z)) * longint'(g);
    v = v >>> 4;
    if (INVERT_POLARITY) v = -v;
    return clip24(v);
  endfunction

  function automatic msfe_out_t snapshot(input logic [14:0] angle, input bit neutral);
    msfe_out_t r;
    r.fault_code     = fault_state;
    r.drive_on       = drive_en;
    r.neutral_pwm    = neutral;
    r.elec_angle_out = angle;
    r.current_a      = phase_filt[0][23:0];
    r.current_b      = phase_filt[1][23:0];
    r.current_c      = phase_filt[2][23:0];
    r.speed_out      = speed_est[23:0];
    return r;
  endfunction

  task automatic clear_shadow();
    regs.zero_offset_a     = 12'd2048;
    regs.zero_offset_b     = 12'd2048;
    regs.zero_offset_c     = 12'd2048;
    regs.gain_a            = '0;
    regs.gain_bc           = '0;
    regs.overcurrent_limit = 23'h7FFFFF;
    regs.angle_offset      = '0;
    regs.lead_min_speed    = 23'h7FFFFF;
    enc_miss_run = '0;
    last_angle   = '0;
    speed_est    = 0;
    speed_primed = 1'b0;
    drive_en     = 1'b0;
    fault_state  = FAULT_NONE;
    for (int i = 0; i < 3; i++) begin
      latched_adc[i] = '0;
      phase_filt[i]  = 0;
    end
  endtask

  // Result word that one accepted tick produces; updates the shadow state.
  function automatic msfe_out_t predict_tick(input msfe_in_t w);
    logic [14:0] angle;
    logic [14:0] diff;
    longint      delta;
    longint      lead;
    longint      raw[3];
    if (w.arm) begin
      drive_en    = 1'b1;
      fault_state = FAULT_NONE;
    end
    if (!w.encoder_ok) begin
      if (enc_miss_run != 8'd255) enc_miss_run = enc_miss_run + 8'd1;
      if (enc_miss_run >= MAX_ENC_FAILS) begin
        drive_en    = 1'b0;
        fault_state = FAULT_ENCODER;
        return snapshot(last_angle, 1'b1);
      end
    end else begin
      enc_miss_run = '0;
    end

    angle = 15'(w.mech_angle * ELEC_PER_MECH - regs.angle_offset);
    if (speed_primed) begin
      diff  = angle - last_angle;
      delta = diff[14] ? longint'(diff) - 32768 : longint'(diff);
      speed_est = clip24(speed_est + ((delta * 256 - speed_est) >>> SPEED_SHIFT));
    end else begin
      speed_est    = 0;
      speed_primed = 1'b1;
    end
    last_angle = angle;

    if (w.adc_ready) begin
      latched_adc[0] = w.sample_a;
      latched_adc[1] = w.sample_b;
      latched_adc[2] = w.sample_c;
    end
    raw[0] = scaled_current(latched_adc[0], regs.zero_offset_a, regs.gain_a);
    raw[1] = scaled_current(latched_adc[1], regs.zero_offset_b, regs.gain_bc);
    raw[2] = scaled_current(latched_adc[2], regs.zero_offset_c, regs.gain_bc);
    for (int i = 0; i < 3; i++)
      phase_filt[i] = clip24(phase_filt[i] + ((raw[i] - phase_filt[i]) >>> CURRENT_SHIFT));

    if (!drive_en) return snapshot(angle, 1'b1);

    for (int i = 0; i < 3; i++) begin
      if (mag(phase_filt[i]) > longint'(regs.overcurrent_limit)) begin
        drive_en    = 1'b0;
        fault_state = FAULT_OVERCURRENT;
        return snapshot(angle, 1'b1);
      end
    end

    if (mag(speed_est) >= longint'(regs.lead_min_speed)) begin
      lead = speed_est / 256;
      if (lead > LEAD_CLAMP) lead = LEAD_CLAMP;
      if (lead < -LEAD_CLAMP) lead = -LEAD_CLAMP;
      angle = angle + 15'(lead);
    end
    return snapshot(angle, 1'b0);
  endfunction

  function automatic msfe_in_t make_tick(input bit ok, input logic [14:0] mech, input bit rdy,
                                         input logic [11:0] a, input logic [11:0] b,
                                         input logic [11:0] c, input bit arm);
    msfe_in_t w;
    w.encoder_ok = ok;
    w.mech_angle = mech;
    w.adc_ready  = rdy;
    w.sample_a   = a;
    w.sample_b   = b;
    w.sample_c   = c;
    w.arm        = arm;
    return w;
  endfunction

  function automatic logic [11:0] draw_sample();
    int v;
    if ($urandom_range(0, 1)) v = 2048 + int'($urandom_range(0, 400)) - 200;
    else v = int'($urandom_range(0, 4095));
    return 12'(v);
  endfunction

  // Fill the unused upper bits of a narrow register with noise.
  function automatic logic [CFG_W-1:0] with_junk(input logic [CFG_W-1:0] v, input int width);
    logic [CFG_W-1:0] mask;
    mask = (CFG_W'(1) << width) - 1'b1;
    return (v & mask) | (CFG_W'($urandom) & ~mask);
  endfunction

  task automatic send_tick(input msfe_in_t w);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due_results.push_back(predict_tick(w));
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic apply_settings(input logic [11:0] za, input logic [11:0] zb,
                                input logic [11:0] zc, input logic [15:0] ga,
                                input logic [15:0] gbc, input logic [22:0] oc_lim,
                                input logic [14:0] ofs, input logic [22:0] lead_min);
    regs.zero_offset_a     = za;
    regs.zero_offset_b     = zb;
    regs.zero_offset_c     = zc;
    regs.gain_a            = ga;
    regs.gain_bc           = gbc;
    regs.overcurrent_limit = oc_lim;
    regs.angle_offset      = ofs;
    regs.lead_min_speed    = lead_min;
    cfg_we    <= 1'b1;
    cfg_index <= REG_ZERO_OFFSET_A;
    cfg_data  <= with_junk(CFG_W'(za), SAMPLE_W);
    @(posedge clk);
    cfg_index <= REG_ZERO_OFFSET_B;
    cfg_data  <= with_junk(CFG_W'(zb), SAMPLE_W);
    @(posedge clk);
    cfg_index <= REG_ZERO_OFFSET_C;
    cfg_data  <= with_junk(CFG_W'(zc), SAMPLE_W);
    @(posedge clk);
    cfg_index <= REG_GAIN_A;
    cfg_data  <= with_junk(CFG_W'(ga), GAIN_W);
    @(posedge clk);
    cfg_index <= REG_GAIN_BC;
    cfg_data  <= with_junk(CFG_W'(gbc), GAIN_W);
    @(posedge clk);
    cfg_index <= REG_OC_LIMIT;
    cfg_data  <= oc_lim;
    @(posedge clk);
    cfg_index <= REG_ANGLE_OFFSET;
    cfg_data  <= with_junk(CFG_W'(ofs), ANGLE_W);
    @(posedge clk);
    cfg_index <= REG_LEAD_MIN;
    cfg_data  <= lead_min;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic randomize_settings();
    apply_settings(12'($urandom), 12'($urandom), 12'($urandom), 16'($urandom),
                   16'($urandom), 23'($urandom_range(0, 8388607)), 15'($urandom),
                   23'($urandom_range(0, 1 << 21)));
  endtask

  // Reset values, first speed tick, angle extremes, arming with no lead.
  task automatic check_reset_defaults();
    send_tick(make_tick(1, 15'd0, 1, 12'd0, 12'd4095, 12'd2048, 0));
    send_tick(make_tick(1, 15'h7FFF, 0, 12'd4095, 12'd0, 12'd4095, 0));
    send_tick(make_tick(1, 15'h4000, 1, 12'd4095, 12'd0, 12'd0, 1));
  endtask

  // Encoder failure run: limit reached, re-arm while failing, recovery, run cleared by a good read.
  task automatic check_encoder_fault();
    wait_all_results();
    apply_settings(12'd2048, 12'd2048, 12'd2048, 16'd300, 16'd300, 23'h7FFFFF, 15'd1000,
                   23'h7FFFFF);
    send_tick(make_tick(1, 15'd100, 1, 12'd3000, 12'd1000, 12'd2048, 1));
    repeat (3) send_tick(make_tick(0, 15'($urandom), 1, draw_sample(), draw_sample(),
                                   draw_sample(), 0));
    send_tick(make_tick(0, 15'd200, 1, 12'd100, 12'd200, 12'd300, 1));
    send_tick(make_tick(1, 15'd300, 0, 12'd0, 12'd0, 12'd0, 1));
    send_tick(make_tick(0, 15'd400, 1, 12'd2500, 12'd1500, 12'd2100, 0));
    send_tick(make_tick(1, 15'd500, 1, 12'd2500, 12'd1500, 12'd2100, 0));
    send_tick(make_tick(0, 15'd600, 1, 12'd2500, 12'd1500, 12'd2100, 0));
    send_tick(make_tick(0, 15'd700, 1, 12'd2500, 12'd1500, 12'd2100, 0));
  endtask

  // Saturating raw currents in both directions trip the drive.
  task automatic check_overcurrent();
    wait_all_results();
    apply_settings(12'd0, 12'd4095, 12'd2048, 16'hFFFF, 16'hFFFF, 23'd50000, 15'd0,
                   23'h7FFFFF);
    send_tick(make_tick(1, 15'd1000, 1, 12'd4095, 12'd0, 12'd2048, 1));
    send_tick(make_tick(1, 15'd1010, 1, 12'd4095, 12'd0, 12'd4095, 1));
    send_tick(make_tick(1, 15'd1020, 1, 12'd0, 12'd4095, 12'd2048, 1));
    send_tick(make_tick(1, 15'd1030, 0, 12'd0, 12'd0, 12'd0, 0));
  endtask

  // Lead always due; fast rotation both ways, forward far enough to drive it into the clamp.
  task automatic check_angle_lead();
    logic [14:0] mech;
    wait_all_results();
    apply_settings(12'd2048, 12'd2048, 12'd2048, 16'd0, 16'd0, 23'h7FFFFF, 15'd0, 23'd0);
    mech = 15'd0;
    send_tick(make_tick(1, mech, 0, 12'd0, 12'd0, 12'd0, 1));
    repeat (4) begin
      mech = mech + 15'd2000;
      send_tick(make_tick(1, mech, 0, 12'd0, 12'd0, 12'd0, 0));
    end
    repeat (4) begin
      mech = mech - 15'd2000;
      send_tick(make_tick(1, mech, 0, 12'd0, 12'd0, 12'd0, 0));
    end
  endtask

  // A long failure run must stick at its ceiling instead of wrapping.
  task automatic check_fail_run_saturation();
    wait_all_results();
    randomize_settings();
    repeat (262) send_tick(make_tick(0, 15'($urandom), $urandom_range(0, 1), draw_sample(),
                                     draw_sample(), draw_sample(), $urandom_range(0, 7) == 0));
    send_tick(make_tick(1, 15'($urandom), 1, draw_sample(), draw_sample(), draw_sample(), 1));
    repeat (3) send_tick(make_tick(0, 15'($urandom), 1, draw_sample(), draw_sample(),
                                   draw_sample(), 0));
  endtask

  // Mostly a spinning rotor with good reads; occasional failure bursts, re-arms and noise.
  task automatic run_random_phase(input int count);
    msfe_in_t w;
    int       pos;
    int       stride;
    int       miss_left;
    pos       = int'($urandom_range(0, 32767));
    stride    = int'($urandom_range(0, 4800)) - 2400;
    miss_left = 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) stride = int'($urandom_range(0, 4800)) - 2400;
      pos = pos + stride + int'($urandom_range(0, 40)) - 20;
      w.mech_angle = 15'(pos);
      if ($urandom_range(0, 15) == 0) w.mech_angle = 15'($urandom);
      if (miss_left == 0 && $urandom_range(0, 30) == 0) miss_left = $urandom_range(1, 5);
      w.encoder_ok = (miss_left == 0);
      if (miss_left != 0) miss_left--;
      w.adc_ready = ($urandom_range(0, 3) != 0);
      w.sample_a  = draw_sample();
      w.sample_b  = draw_sample();
      w.sample_c  = draw_sample();
      w.arm       = (n == 0) || ($urandom_range(0, 19) == 0);
      send_tick(w);
    end
  endtask

  task automatic check_random_settings();
    wait_all_results();
    apply_settings(12'(2000 + $urandom_range(0, 100)), 12'(2000 + $urandom_range(0, 100)),
                   12'(2000 + $urandom_range(0, 100)), 16'($urandom_range(0, 4000)),
                   16'($urandom_range(0, 4000)), 23'($urandom_range(1 << 20, 8388607)),
                   15'($urandom), 23'($urandom_range(0, 1 << 21)));
    run_random_phase(130);
    wait_all_results();
    apply_settings(12'd0, 12'd4095, 12'd0, 16'hFFFF, 16'hFFFF, 23'd0, 15'h7FFF, 23'd0);
    run_random_phase(90);
    wait_all_results();
    apply_settings(12'd4095, 12'd0, 12'd4095, 16'hFFFF, 16'hFFFF, 23'h7FFFFF, 15'd0,
                   23'h7FFFFF);
    run_random_phase(90);
    wait_all_results();
    randomize_settings();
    run_random_phase(120);
  endtask

  // Tail of the run with both sides streaming at full rate.
  task automatic check_full_rate();
    wait_all_results();
    idling_on = 1'b0;
    randomize_settings();
    run_random_phase(120);
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (idling_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic compare_field(input string fld, input logic [23:0] want, input logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("word %0d: %s expected %h, got %h", words_seen, fld, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    msfe_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("word %0d: unexpected result %h", words_seen, out_data);
      end else begin
        want = due_results.pop_front();
        compare_field("fault_code", 24'(want.fault_code), 24'(out_data.fault_code));
        compare_field("drive_on", 24'(want.drive_on), 24'(out_data.drive_on));
        compare_field("neutral_pwm", 24'(want.neutral_pwm), 24'(out_data.neutral_pwm));
        compare_field("elec_angle_out", 24'(want.elec_angle_out),
                      24'(out_data.elec_angle_out));
        compare_field("current_a", want.current_a, out_data.current_a);
        compare_field("current_b", want.current_b, out_data.current_b);
        compare_field("current_c", want.current_c, out_data.current_c);
        compare_field("speed_out", want.speed_out, out_data.speed_out);
      end
      words_seen++;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_ZERO_OFFSET_A;
    cfg_data  <= '0;
    clear_shadow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_reset_defaults();
    check_encoder_fault();
    check_overcurrent();
    check_angle_lead();
    check_fail_run_saturation();
    check_random_settings();
    check_full_rate();

    wait_all_results();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/msfe_pkg.sv
rtl/msfe_front.sv
rtl/msfe_queue.sv
rtl/msfe_back.sv
rtl/motor_sense_front_end.sv
rtl/msfe_checker.sv
dv/tb_motor_sense_front_end.sv
